// File: sv/ner_pkg.sv
// Shared types and constants for the note event recorder.
// Used by ner_ctrl, ner_dpath, note_event_recorder and ner_checker; depends on nothing.
package ner_pkg;

    // Field widths of the stream items and of one table entry.
    localparam int NOTE_W  = 8;
    localparam int TIME_W  = 16;
    localparam int LEN_W   = 8;
    localparam int COUNT_W = 9;

    // Packed widths of the stream buses (whole bytes).
    localparam int S_TDATA_W = 24;
    localparam int M_TDATA_W = 16;

    // Default number of table entries.
    localparam int DEFAULT_TABLE_DEPTH = 256;

    // One stored note event; a zero length marks the note as still open.
    typedef struct packed {
        logic [NOTE_W-1:0] note;
        logic [TIME_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } t_entry;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_RESULT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // capture the input item
        logic append;     // write a new open entry
        logic start_scan; // point the walk at the newest entry
        logic issue_read; // read the next older entry
        logic close;      // write the length into the matched entry
        logic fail;       // the event is rejected
        logic publish;    // move the result into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_on;    // latched item is a note-on
        logic full;     // table holds TABLE_DEPTH entries
        logic ptr_zero; // no older entry left to read
        logic rd_valid; // read data belongs to the walk
        logic hit;      // read entry is open and has the same note
        logic out_free; // output register can take a result
    } t_status;

endpackage

// File: sv/ner_ctrl.sv
// Controller state machine of the note event recorder.
// Depends on ner_pkg for the state, command and status types.
module ner_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  ner_pkg::t_status i_status,
    output logic             o_in_ready,
    output ner_pkg::t_cmd    o_cmd
);
    import ner_pkg::*;

    t_state r_state;
    t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = i_status.is_on ? S_RESULT : S_SCAN;
            end
            S_SCAN: begin
                if ((i_status.rd_valid && i_status.hit) || i_status.ptr_zero) begin
                    n_state = S_RESULT;
                end
            end
            S_RESULT: begin
                if (i_status.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Commands for the datapath.
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            S_DECODE: begin
                if (i_status.is_on) begin
                    o_cmd.append = !i_status.full;
                    o_cmd.fail   = i_status.full;
                end else begin
                    o_cmd.start_scan = 1'b1;
                end
            end
            S_SCAN: begin
                // A match ends the walk; otherwise the walk stops when no entry is left.
                priority if (i_status.rd_valid && i_status.hit) begin
                    o_cmd.close = 1'b1;
                end else if (i_status.ptr_zero) begin
                    o_cmd.fail = 1'b1;
                end else begin
                    o_cmd.issue_read = 1'b1;
                end
            end
            S_RESULT: begin
                o_cmd.publish = i_status.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end

endmodule

// File: sv/ner_dpath.sv
// Datapath of the note event recorder: entry table, fill count, walk pointer
// and output register. Depends on ner_pkg for field widths and the command types.
module ner_dpath #(
    parameter int TABLE_DEPTH = ner_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ner_pkg::t_cmd                 i_cmd,
    input  logic [ner_pkg::NOTE_W-1:0]    i_note,
    input  logic [ner_pkg::TIME_W-1:0]    i_time,
    input  logic                          i_on,
    input  logic                          i_out_ready,
    output ner_pkg::t_status              o_status,
    output logic                          o_out_valid,
    output logic                          o_out_ok,
    output logic [ner_pkg::COUNT_W-1:0]   o_out_count
);
    import ner_pkg::*;

    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    // Entry table.
    t_entry mem [TABLE_DEPTH];

    // Latched input item.
    logic [NOTE_W-1:0] r_note;
    logic [TIME_W-1:0] r_time;
    logic              r_on;

    // Table bookkeeping and walk state.
    logic [CW-1:0]     r_fill;
    logic [CW-1:0]     r_ptr;
    logic [CW-1:0]     ptr_dec;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     r_rd_addr;
    t_entry            r_rd_data;
    logic              r_rd_valid;
    logic              r_ok;

    // Write side of the table.
    t_entry            wr_data;
    logic [AW-1:0]     wr_addr;
    logic              wr_en;
    logic [TIME_W-1:0] time_diff;

    // Output register.
    logic                    r_out_valid;
    logic                    r_out_ok;
    logic [COUNT_W-1:0]      r_out_count;
    logic [CW+COUNT_W-1:0]   fill_ext;

    assign ptr_dec   = r_ptr - CW'(1);
    assign rd_addr   = ptr_dec[AW-1:0];
    assign time_diff = r_time - r_rd_data.start;
    assign fill_ext  = {{COUNT_W{1'b0}}, r_fill};

    // Capture the input item on a transfer.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_note <= i_note;
            r_time <= i_time;
            r_on   <= i_on;
        end
    end

    // Table write: a new open entry, or the length of the matched entry.
    always_comb begin
        wr_en   = i_cmd.append || i_cmd.close;
        wr_addr = r_rd_addr;
        wr_data = r_rd_data;
        if (i_cmd.append) begin
            wr_addr        = r_fill[AW-1:0];
            wr_data.note   = r_note;
            wr_data.start  = r_time;
            wr_data.length = '0;
        end else begin
            wr_data.length = time_diff[LEN_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered table read during the walk.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue_read) begin
            r_rd_data <= mem[rd_addr];
            r_rd_addr <= rd_addr;
        end
    end

    // Fill count, walk pointer and read tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_ptr      <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            r_rd_valid <= i_cmd.issue_read;
            if (i_cmd.append) begin
                r_fill <= r_fill + CW'(1);
            end
            if (i_cmd.start_scan) begin
                r_ptr <= r_fill;
            end else if (i_cmd.issue_read) begin
                r_ptr <= ptr_dec;
            end
        end
    end

    // Outcome of the current event.
    always_ff @(posedge i_clk) begin
        if (i_cmd.append || i_cmd.close) begin
            r_ok <= 1'b1;
        end else if (i_cmd.fail) begin
            r_ok <= 1'b0;
        end
    end

    // Output register; it frees when its transfer completes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.publish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.publish) begin
            r_out_ok    <= r_ok;
            r_out_count <= fill_ext[COUNT_W-1:0];
        end
    end

    // Status for the controller.
    always_comb begin
        o_status.is_on    = r_on;
        o_status.full     = (r_fill == CW'(TABLE_DEPTH));
        o_status.ptr_zero = (r_ptr == '0);
        o_status.rd_valid = r_rd_valid;
        o_status.hit      = (r_rd_data.note == r_note) && (r_rd_data.length == '0);
        o_status.out_free = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_ok    = r_out_ok;
    assign o_out_count = r_out_count;

endmodule

// File: sv/note_event_recorder.sv
// Top level of the note event recorder: stream ports around the controller and datapath.
// Depends on ner_pkg, ner_ctrl and ner_dpath.
//
// Each note event yields exactly one result. A note-on passes from its transfer
// through the decode state to the result state; a note-off walks the table from
// the newest entry back one entry per cycle through the single read port of the
// entry table, until it finds a match or no older entry is left. The next event
// is taken once the current one has placed its result in the output register,
// even while that result still waits to be taken. The table needs no clearing
// after reset: only entries below the fill count are read.
module note_event_recorder #(
    parameter int TABLE_DEPTH = ner_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ner_pkg::S_TDATA_W-1:0]   s_tdata,  // [7:0] note_number, [23:8] event_time
    input  logic                            s_tuser,  // [0] is_note_on
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ner_pkg::M_TDATA_W-1:0]   m_tdata,  // [8:0] entry_count, [15:9] zero
    output logic                            m_tuser   // [0] accepted
);
    import ner_pkg::*;

    t_cmd               cmd;
    t_status            status;
    logic [COUNT_W-1:0] out_count;

    // Controller.
    ner_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .i_status   (status),
        .o_in_ready (s_tready),
        .o_cmd      (cmd)
    );

    // Datapath.
    ner_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_note      (s_tdata[NOTE_W-1:0]),
        .i_time      (s_tdata[NOTE_W+TIME_W-1:NOTE_W]),
        .i_on        (s_tuser),
        .i_out_ready (m_tready),
        .o_status    (status),
        .o_out_valid (m_tvalid),
        .o_out_ok    (m_tuser),
        .o_out_count (out_count)
    );

    assign m_tdata = {{(M_TDATA_W-COUNT_W){1'b0}}, out_count};

endmodule

// File: sv/ner_checker.sv
// Port-level checks for the note event recorder, bound to its top level.
// Depends on ner_pkg for bus widths.
module ner_port_checks #(
    parameter int TABLE_DEPTH = ner_pkg::DEFAULT_TABLE_DEPTH
) (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_s_tvalid,
    input logic                            i_s_tready,
    input logic                            i_m_tvalid,
    input logic                            i_m_tready,
    input logic [ner_pkg::M_TDATA_W-1:0]   i_m_tdata,
    input logic                            i_m_tuser
);
    import ner_pkg::*;

    // A result stays offered until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> i_m_tvalid)
        else $error("result withdrawn before transfer");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=> $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("stalled result changed");

    // One event at a time: the input closes right after a transfer.
    a_one_event: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && i_s_tready |=> !i_s_tready)
        else $error("input open during event processing");

    // The reported count never exceeds the table depth (checked for depths up to 511), and padding bits are zero.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> ((TABLE_DEPTH > 511) || (i_m_tdata[COUNT_W-1:0] <= TABLE_DEPTH))
                       && (i_m_tdata[M_TDATA_W-1:COUNT_W] == '0))
        else $error("entry count out of range");

endmodule

bind note_event_recorder ner_port_checks #(
    .TABLE_DEPTH (TABLE_DEPTH)
) u_ner_port_checks (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_tvalid),
    .i_s_tready (s_tready),
    .i_m_tvalid (m_tvalid),
    .i_m_tready (m_tready),
    .i_m_tdata  (m_tdata),
    .i_m_tuser  (m_tuser)
);
